// ===== rtl/lams_pkg.sv =====
// Shared types, codes and helpers for the lattice atom move step core.
// No dependencies; imported by lattice_atom_move_step_core.
package lams_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam logic [1:0] CMD_PLACE = 2'd0;
  localparam logic [1:0] CMD_DIR   = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_STEPS   = 2'd2;

  localparam logic [6:0]  RST_GRID_WIDTH  = 7'd64;
  localparam logic [6:0]  RST_GRID_HEIGHT = 7'd64;
  localparam logic [31:0] RST_MAX_STEPS   = 32'd1000;

  localparam logic [3:0]  CLAIM_MAX = 4'hF;
  localparam logic [15:0] COLL_MAX  = 16'hFFFF;

  typedef struct packed {
    logic              occ;
    logic [2:0]        kind;
    logic signed [15:0] mdx;
    logic signed [15:0] mdy;
    logic signed [15:0] wdx;
    logic signed [15:0] wdy;
    logic [15:0]       coll;
  } rec_t;

  // east is column plus one
  function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
    logic signed [1:0] r;
    case (d) inside
      3'd1, 3'd2, 3'd3: r = 2'sd1;
      3'd5, 3'd6, 3'd7: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  // north is row minus one
  function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
    logic signed [1:0] r;
    case (d) inside
      3'd0, 3'd1, 3'd7: r = -2'sd1;
      3'd3, 3'd4, 3'd5: r = 2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                   input logic signed [1:0] d);
    logic signed [16:0] s;
    s = 17'(a) + 17'(d);
    if (s > 17'sd32767) return 16'sh7FFF;
    if (s < -17'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction

  function automatic logic [3:0] claim_inc(input logic [3:0] v);
    return (v == CLAIM_MAX) ? v : v + 4'd1;
  endfunction

endpackage

// ===== rtl/lams_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lams_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lattice_atom_move_step_core.sv =====
// Toroidal atom lattice: cell records, directions and claims held in RAMs.
// Depends on lams_pkg and lams_ram.
// Place, direction and read first reduce cell_x/cell_y into the grid by 0 to 63
//   wrap subtractions, then pass the address, execute and finish states (a read also a record read state).
// A step clears the claims of the used w*h cells, then runs a claim pass (each occupied
//   cell claims itself and its target), then a move pass that skips, blocks or moves each atom;
//   the claim RAM has one write port and one read port. One item at a time.
// Reset is synchronous; it starts a clearing pass over all MAX_COLUMNS*MAX_ROWS
//   cells of the record and direction RAMs, during which no item is taken.
module lattice_atom_move_step_core #(
  parameter int MAX_COLUMNS = lams_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = lams_pkg::DEF_MAX_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [5:0]         cell_x,
  input  logic [5:0]         cell_y,
  input  logic               occupied,
  input  logic [2:0]         atom_type,
  input  logic [2:0]         direction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               cell_occupied,
  output logic [2:0]         cell_type,
  output logic signed [15:0] moved_dx,
  output logic signed [15:0] moved_dy,
  output logic signed [15:0] wanted_dx,
  output logic signed [15:0] wanted_dy,
  output logic [15:0]        collision_total,
  output logic               step_ran,
  output logic [31:0]        steps_done
);
  import lams_pkg::*;

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW = $clog2(CELLS);
  localparam int XW = $clog2(MAX_COLUMNS);
  localparam int YW = $clog2(MAX_ROWS);
  localparam int WW = XW + 1;
  localparam int HW = YW + 1;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_WRAP  = 5'd2;
  localparam logic [4:0] S_ADDR  = 5'd3;
  localparam logic [4:0] S_EXEC  = 5'd4;
  localparam logic [4:0] S_RD    = 5'd5;
  localparam logic [4:0] S_FIN   = 5'd6;
  localparam logic [4:0] S_Z     = 5'd7;
  localparam logic [4:0] S_C0    = 5'd8;
  localparam logic [4:0] S_C1    = 5'd9;
  localparam logic [4:0] S_C2    = 5'd10;
  localparam logic [4:0] S_C3    = 5'd11;
  localparam logic [4:0] S_C4    = 5'd12;
  localparam logic [4:0] S_M0    = 5'd13;
  localparam logic [4:0] S_M1    = 5'd14;
  localparam logic [4:0] S_M2    = 5'd15;
  localparam logic [4:0] S_M3    = 5'd16;
  localparam logic [4:0] S_M4    = 5'd17;
  localparam logic [4:0] S_M5    = 5'd18;

  logic [4:0]  state, state_next;
  logic [6:0]  grid_width, grid_height;
  logic [31:0] max_steps, step_count;

  logic [1:0]  cmd_r;
  logic [5:0]  cx, cy;
  logic        occ_r;
  logic [2:0]  type_r, dir_val;

  logic [AW-1:0] lin, taddr;
  logic [XW-1:0] px, tx, nx;
  logic [YW-1:0] py, ty, ny;
  logic [2:0]    cdir;
  logic [3:0]    cclm;
  rec_t          cur;
  logic          ran_r;

  logic [WW-1:0] used_w;
  logic [HW-1:0] used_h;
  logic          px_last, py_last, at_end, cx_ok, cy_ok;
  logic          pos_clr, pos_adv, step_end;
  logic signed [1:0] rdx, rdy, cdx, cdy;

  logic          rec_we, dir_we, clm_we;
  logic [AW-1:0] rec_waddr, clm_waddr, clm_raddr;
  rec_t          rec_wdata, rec_rdata, rec_mod;
  logic [2:0]    dir_wdata, dir_rdata;
  logic [3:0]    clm_wdata, clm_rdata;

  lams_ram #(.WIDTH($bits(rec_t)), .DEPTH(CELLS)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(lin), .rdata(rec_rdata)
  );
  lams_ram #(.WIDTH(3), .DEPTH(CELLS)) u_dir (
    .clk(clk), .we(dir_we), .waddr(lin), .wdata(dir_wdata),
    .raddr(lin), .rdata(dir_rdata)
  );
  lams_ram #(.WIDTH(4), .DEPTH(CELLS)) u_clm (
    .clk(clk), .we(clm_we), .waddr(clm_waddr), .wdata(clm_wdata),
    .raddr(clm_raddr), .rdata(clm_rdata)
  );

  always_comb begin
    if (grid_width == '0) used_w = WW'(1);
    else if (32'(grid_width) > MAX_COLUMNS) used_w = WW'(MAX_COLUMNS);
    else used_w = WW'(grid_width);
    if (grid_height == '0) used_h = HW'(1);
    else if (32'(grid_height) > MAX_ROWS) used_h = HW'(MAX_ROWS);
    else used_h = HW'(grid_height);
  end

  assign px_last = (WW'(px) == used_w - WW'(1));
  assign py_last = (HW'(py) == used_h - HW'(1));
  assign at_end  = px_last && py_last;
  assign cx_ok   = 32'(cx) < 32'(used_w);
  assign cy_ok   = 32'(cy) < 32'(used_h);

  // target of the atom at (px, py) with the direction just read
  assign rdx = dir_dx(dir_rdata);
  assign rdy = dir_dy(dir_rdata);
  assign cdx = dir_dx(cdir);
  assign cdy = dir_dy(cdir);

  always_comb begin
    if (rdx == 2'sd1) nx = px_last ? '0 : px + XW'(1);
    else if (rdx == -2'sd1) nx = (px == '0) ? XW'(used_w - WW'(1)) : px - XW'(1);
    else nx = px;
    if (rdy == 2'sd1) ny = py_last ? '0 : py + YW'(1);
    else if (rdy == -2'sd1) ny = (py == '0) ? YW'(used_h - HW'(1)) : py - YW'(1);
    else ny = py;
  end

  always_comb begin
    rec_mod      = rec_rdata;
    rec_mod.wdx  = sat_add16(rec_rdata.wdx, rdx);
    rec_mod.wdy  = sat_add16(rec_rdata.wdy, rdy);
  end

  always_comb begin
    state_next = state;
    pos_clr    = 1'b0;
    pos_adv    = 1'b0;
    step_end   = 1'b0;
    rec_we     = 1'b0;
    rec_waddr  = lin;
    rec_wdata  = '0;
    dir_we     = 1'b0;
    dir_wdata  = dir_val;
    clm_we     = 1'b0;
    clm_waddr  = lin;
    clm_wdata  = '0;
    clm_raddr  = lin;
    unique case (state)
      S_CLEAR: begin
        rec_we    = 1'b1;
        dir_we    = 1'b1;
        dir_wdata = '0;
        pos_adv   = 1'b1;
        if (lin == LAST_CELL) begin
          pos_clr    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (cmd != CMD_STEP) begin
            state_next = S_WRAP;
          end else if (step_count < max_steps) begin
            pos_clr    = 1'b1;
            state_next = S_Z;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_WRAP: if (cx_ok && cy_ok) state_next = S_ADDR;
      S_ADDR: state_next = S_EXEC;
      S_EXEC: begin
        unique case (cmd_r)
          CMD_PLACE: begin
            rec_we         = 1'b1;
            rec_wdata.occ  = occ_r;
            rec_wdata.kind = occ_r ? type_r : 3'd0;
            state_next     = S_FIN;
          end
          CMD_DIR: begin
            dir_we     = 1'b1;
            state_next = S_FIN;
          end
          default: state_next = S_RD;
        endcase
      end
      S_RD: state_next = S_FIN;
      S_FIN: if (!out_valid || !out_stall) state_next = S_IDLE;
      S_Z: begin
        clm_we = 1'b1;
        if (at_end) begin
          pos_clr    = 1'b1;
          state_next = S_C0;
        end else begin
          pos_adv = 1'b1;
        end
      end
      S_C0: state_next = S_C1;
      S_C1: begin
        if (rec_rdata.occ) state_next = S_C2;
        else if (at_end) begin
          pos_clr    = 1'b1;
          state_next = S_M0;
        end else begin
          pos_adv    = 1'b1;
          state_next = S_C0;
        end
      end
      S_C2: begin
        clm_we     = 1'b1;
        clm_wdata  = claim_inc(clm_rdata);
        state_next = S_C3;
      end
      S_C3: begin
        clm_raddr  = taddr;
        state_next = S_C4;
      end
      S_C4: begin
        clm_we    = 1'b1;
        clm_waddr = taddr;
        clm_wdata = claim_inc(clm_rdata);
        if (at_end) begin
          pos_clr    = 1'b1;
          state_next = S_M0;
        end else begin
          pos_adv    = 1'b1;
          state_next = S_C0;
        end
      end
      S_M0: state_next = S_M1;
      S_M1: begin
        if (rec_rdata.occ && clm_rdata != 4'd0) state_next = S_M2;
        else if (at_end) begin
          step_end   = 1'b1;
          state_next = S_FIN;
        end else begin
          pos_adv    = 1'b1;
          state_next = S_M0;
        end
      end
      S_M2: state_next = S_M3;
      S_M3: begin
        clm_raddr  = taddr;
        state_next = S_M4;
      end
      S_M4: begin
        if (cclm == 4'd1 && clm_rdata == 4'd1) begin
          rec_we        = 1'b1;
          rec_waddr     = taddr;
          rec_wdata     = cur;
          rec_wdata.mdx = sat_add16(cur.mdx, cdx);
          rec_wdata.mdy = sat_add16(cur.mdy, cdy);
          clm_we        = 1'b1;
          clm_waddr     = taddr;
          state_next    = S_M5;
        end else begin
          rec_we         = 1'b1;
          rec_wdata      = cur;
          rec_wdata.coll = (cur.coll == COLL_MAX) ? cur.coll : cur.coll + 16'd1;
          clm_we         = 1'b1;
          if (at_end) begin
            step_end   = 1'b1;
            state_next = S_FIN;
          end else begin
            pos_adv    = 1'b1;
            state_next = S_M0;
          end
        end
      end
      S_M5: begin
        rec_we = 1'b1;
        if (at_end) begin
          step_end   = 1'b1;
          state_next = S_FIN;
        end else begin
          pos_adv    = 1'b1;
          state_next = S_M0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // raster position; lin tracks px + py * width
  always_ff @(posedge clk) begin
    if (rst) begin
      lin <= '0;
      px  <= '0;
      py  <= '0;
    end else if (pos_clr) begin
      lin <= '0;
      px  <= '0;
      py  <= '0;
    end else if (pos_adv) begin
      lin <= lin + AW'(1);
      px  <= px_last ? '0 : px + XW'(1);
      py  <= px_last ? py + YW'(1) : py;
    end else if (state == S_ADDR) begin
      lin <= AW'(cx) + AW'(32'(cy) * 32'(used_w));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      grid_width  <= RST_GRID_WIDTH;
      grid_height <= RST_GRID_HEIGHT;
      max_steps   <= RST_MAX_STEPS;
      step_count  <= '0;
      out_valid   <= 1'b0;
      ran_r       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data[6:0];
          REG_GRID_HEIGHT: grid_height <= cfg_data[6:0];
          REG_MAX_STEPS:   max_steps   <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_IDLE && in_valid) begin
        ran_r <= 1'b0;
      end
      if (step_end) begin
        step_count <= step_count + 32'd1;
        ran_r      <= 1'b1;
      end
      if (state == S_FIN && state_next == S_IDLE) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_r   <= cmd;
      cx      <= cell_x;
      cy      <= cell_y;
      occ_r   <= occupied;
      type_r  <= atom_type;
      dir_val <= direction;
    end
    if (state == S_WRAP) begin
      if (!cx_ok) cx <= cx - 6'(used_w);
      if (!cy_ok) cy <= cy - 6'(used_h);
    end
    if (state == S_RD) begin
      cur <= rec_rdata;
    end
    if (state == S_C1 || state == S_M1) begin
      tx   <= nx;
      ty   <= ny;
      cdir <= dir_rdata;
      cclm <= clm_rdata;
      cur  <= rec_mod;
    end
    if (state == S_C2 || state == S_M2) begin
      taddr <= AW'(tx) + AW'(32'(ty) * 32'(used_w));
    end
    if (state == S_FIN && state_next == S_IDLE) begin
      if (cmd_r == CMD_READ) begin
        cell_occupied   <= cur.occ;
        cell_type       <= cur.kind;
        moved_dx        <= cur.mdx;
        moved_dy        <= cur.mdy;
        wanted_dx       <= cur.wdx;
        wanted_dy       <= cur.wdy;
        collision_total <= cur.coll;
      end else begin
        cell_occupied   <= 1'b0;
        cell_type       <= '0;
        moved_dx        <= '0;
        moved_dy        <= '0;
        wanted_dx       <= '0;
        wanted_dy       <= '0;
        collision_total <= '0;
      end
      step_ran   <= ran_r;
      steps_done <= step_count;
    end
  end

  a_steps_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> step_count >= $past(step_count))
    else $error("step count went backwards");

  a_wrap_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ADDR |-> (cx_ok && cy_ok))
    else $error("cell address left wrap unit out of range");

  a_claim_consumed: assert property (@(posedge clk) disable iff (rst)
    (state == S_M4 && clm_we) |-> clm_wdata == 4'd0)
    else $error("move pass wrote a nonzero claim");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside finish state");

endmodule

// ===== test/lattice_atom_move_step_core_tb.sv =====
// Self-checking testbench for lattice_atom_move_step_core.
// Depends on lams_pkg; keeps its own lattice predictor and checks the result of every item.
`timescale 1ns / 1ps

module lattice_atom_move_step_core_tb;
  import lams_pkg::*;

  localparam int COLS = DEF_MAX_COLUMNS;
  localparam int ROWS = DEF_MAX_ROWS;
  localparam int CELLS = COLS * ROWS;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    logic              occ;
    logic [2:0]        kind;
    logic signed [15:0] mdx;
    logic signed [15:0] mdy;
    logic signed [15:0] wdx;
    logic signed [15:0] wdy;
    logic [15:0]       coll;
    logic              ran;
    logic [31:0]       steps;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic [5:0] cell_x = '0;
  logic [5:0] cell_y = '0;
  logic occupied = 1'b0;
  logic [2:0] atom_type = '0;
  logic [2:0] direction = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cell_occupied;
  logic [2:0] cell_type;
  logic signed [15:0] moved_dx, moved_dy, wanted_dx, wanted_dy;
  logic [15:0] collision_total;
  logic step_ran;
  logic [31:0] steps_done;

  lattice_atom_move_step_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .cell_x(cell_x), .cell_y(cell_y),
    .occupied(occupied), .atom_type(atom_type), .direction(direction),
    .out_valid(out_valid), .out_stall(out_stall), .cell_occupied(cell_occupied),
    .cell_type(cell_type), .moved_dx(moved_dx), .moved_dy(moved_dy), .wanted_dx(wanted_dx),
    .wanted_dy(wanted_dy), .collision_total(collision_total), .step_ran(step_ran),
    .steps_done(steps_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lattice shadow state
  logic [6:0]  lat_width, lat_height;
  logic [31:0] lat_step_limit, lat_steps;
  logic        lat_occ  [CELLS];
  logic [2:0]  lat_kind [CELLS];
  logic signed [15:0] lat_mdx [CELLS], lat_mdy [CELLS], lat_wdx [CELLS], lat_wdy [CELLS];
  logic [15:0] lat_coll [CELLS];
  logic [2:0]  lat_dir  [CELLS];
  logic [3:0]  lat_claim [CELLS];

  cell_result_t pending_results[$];
  int mismatches = 0;
  int idle_mode = 1;     // 0 no gaps, 1 mostly short gaps, 2 frequent long gaps
  int stall_mode = 1;

  function automatic int eff_width();
    if (lat_width == 0) return 1;
    if (lat_width > COLS) return COLS;
    return int'(lat_width);
  endfunction

  function automatic int eff_height();
    if (lat_height == 0) return 1;
    if (lat_height > ROWS) return ROWS;
    return int'(lat_height);
  endfunction

  function automatic int step_x(input logic [2:0] d);
    if (d inside {3'd1, 3'd2, 3'd3}) return 1;
    if (d inside {3'd5, 3'd6, 3'd7}) return -1;
    return 0;
  endfunction

  function automatic int step_y(input logic [2:0] d);
    if (d inside {3'd0, 3'd1, 3'd7}) return -1;
    if (d inside {3'd3, 3'd4, 3'd5}) return 1;
    return 0;
  endfunction

  function automatic logic signed [15:0] clamp_add(input logic signed [15:0] a, input int d);
    int s;
    s = int'(a) + d;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return 16'(s);
  endfunction

  function automatic void clear_record(input int i);
    lat_occ[i] = 1'b0;
    lat_kind[i] = '0;
    lat_mdx[i] = '0;
    lat_mdy[i] = '0;
    lat_wdx[i] = '0;
    lat_wdy[i] = '0;
    lat_coll[i] = '0;
  endfunction

  function automatic void lattice_reset();
    lat_width = RST_GRID_WIDTH;
    lat_height = RST_GRID_HEIGHT;
    lat_step_limit = RST_MAX_STEPS;
    lat_steps = '0;
    for (int i = 0; i < CELLS; i++) begin
      clear_record(i);
      lat_dir[i] = '0;
      lat_claim[i] = '0;
    end
  endfunction

  function automatic void claim_bump(input int i);
    if (lat_claim[i] != 4'hF) lat_claim[i] = lat_claim[i] + 4'd1;
  endfunction

  function automatic void lattice_move_round();
    int w, h, i, t, dx, dy;
    w = eff_width();
    h = eff_height();
    for (int k = 0; k < CELLS; k++) lat_claim[k] = '0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        i = x + y * w;
        if (lat_occ[i]) begin
          dx = step_x(lat_dir[i]);
          dy = step_y(lat_dir[i]);
          claim_bump(i);
          claim_bump((x + w + dx) % w + ((y + h + dy) % h) * w);
        end
      end
    end
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        i = x + y * w;
        if (lat_occ[i] && lat_claim[i] != 0) begin
          dx = step_x(lat_dir[i]);
          dy = step_y(lat_dir[i]);
          t = (x + w + dx) % w + ((y + h + dy) % h) * w;
          lat_wdx[i] = clamp_add(lat_wdx[i], dx);
          lat_wdy[i] = clamp_add(lat_wdy[i], dy);
          if (lat_claim[i] == 1 && lat_claim[t] == 1) begin
            lat_mdx[t] = clamp_add(lat_mdx[i], dx);
            lat_mdy[t] = clamp_add(lat_mdy[i], dy);
            lat_wdx[t] = lat_wdx[i];
            lat_wdy[t] = lat_wdy[i];
            lat_coll[t] = lat_coll[i];
            lat_occ[t] = 1'b1;
            lat_kind[t] = lat_kind[i];
            clear_record(i);
            lat_claim[t] = '0;
          end else begin
            if (lat_coll[i] != 16'hFFFF) lat_coll[i] = lat_coll[i] + 16'd1;
            lat_claim[i] = '0;
          end
        end
      end
    end
  endfunction

  function automatic cell_result_t lattice_apply(input logic [1:0] c, input logic [5:0] x,
                                                 input logic [5:0] y, input logic occ,
                                                 input logic [2:0] typ, input logic [2:0] dir);
    cell_result_t r;
    int i;
    r = '0;
    i = int'(x) % eff_width() + (int'(y) % eff_height()) * eff_width();
    case (c)
      CMD_PLACE: begin
        clear_record(i);
        lat_occ[i] = occ;
        lat_kind[i] = occ ? typ : 3'd0;
      end
      CMD_DIR: lat_dir[i] = dir;
      CMD_STEP: begin
        if (lat_steps < lat_step_limit) begin
          lattice_move_round();
          lat_steps = lat_steps + 32'd1;
          r.ran = 1'b1;
        end
      end
      default: begin
        r.occ = lat_occ[i];
        r.kind = lat_kind[i];
        r.mdx = lat_mdx[i];
        r.mdy = lat_mdy[i];
        r.wdx = lat_wdx[i];
        r.wdy = lat_wdy[i];
        r.coll = lat_coll[i];
      end
    endcase
    r.steps = lat_steps;
    return r;
  endfunction

  function automatic int pick_gap(input int mode);
    int p;
    if (mode == 0) return 0;
    p = $urandom_range(0, 99);
    if (mode == 2 && p < 30) return $urandom_range(10, 40);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic [1:0] c, input logic [5:0] x, input logic [5:0] y,
                           input logic occ, input logic [2:0] typ, input logic [2:0] dir);
    int gap;
    logic stalled;
    gap = pick_gap(idle_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    cell_x <= x;
    cell_y <= y;
    occupied <= occ;
    atom_type <= typ;
    direction <= dir;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    pending_results.insert(pending_results.size(), lattice_apply(c, x, y, occ, typ, dir));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic ready_seen;
    wait_drained();
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:  lat_width = val[6:0];
      REG_GRID_HEIGHT: lat_height = val[6:0];
      default:         lat_step_limit = val;
    endcase
  endtask

  task automatic place(input int x, input int y, input logic [2:0] typ, input logic [2:0] dir);
    send_item(CMD_DIR, 6'(x), 6'(y), 1'b0, 3'd0, dir);
    send_item(CMD_PLACE, 6'(x), 6'(y), 1'b1, typ, 3'd0);
  endtask

  task automatic peek(input int x, input int y);
    send_item(CMD_READ, 6'(x), 6'(y), 1'b0, 3'd0, 3'd0);
  endtask

  // result checker; sampled at the falling edge, where handshake signals are stable
  always @(negedge clk) begin
    cell_result_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = {cell_occupied, cell_type, moved_dx, moved_dy, wanted_dx, wanted_dy,
             collision_total, step_ran, steps_done};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch: exp occ=%0d typ=%0d m=(%0d,%0d) w=(%0d,%0d) ",
                   want.occ, want.kind, want.mdx, want.mdy, want.wdx, want.wdy);
            $write("coll=%0d ran=%0d steps=%0d | ", want.coll, want.ran, want.steps);
            $write("got occ=%0d typ=%0d m=(%0d,%0d) w=(%0d,%0d) ",
                   got.occ, got.kind, got.mdx, got.mdy, got.wdx, got.wdy);
            $display("coll=%0d ran=%0d steps=%0d", got.coll, got.ran, got.steps);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    int p;
    p = $urandom_range(0, 99);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= (p < 25);
      default: out_stall <= (p < 70);
    endcase
  end

  // watchdog: cycles with no transaction on any channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAIL lattice_atom_move_step_core");
      $finish;
    end
  end

  task automatic test_full_grid();
    peek(0, 0);
    peek(63, 63);
    place(63, 63, 3'd7, 3'd3);       // wraps to (0,0) on a move
    place(0, 0, 3'd0, 3'd0);         // north from row 0 wraps to row 63
    place(10, 5, 3'd1, 3'd2);        // pair contesting (11,5), both blocked
    place(12, 5, 3'd2, 3'd6);
    place(20, 20, 3'd4, 3'd1);
    send_item(CMD_STEP, 6'd0, 6'd0, 1'b0, 3'd0, 3'd0);
    peek(0, 0);
    peek(0, 63);
    peek(10, 5);
    peek(21, 19);
    peek(20, 20);
    send_item(CMD_PLACE, 6'd10, 6'd5, 1'b0, 3'd5, 3'd0);
    peek(10, 5);
  endtask

  task automatic test_size_wrap();
    write_reg(REG_GRID_WIDTH, 32'd0);      // acts as one column
    write_reg(REG_GRID_HEIGHT, 32'd127);   // acts as all rows
    place(45, 3, 3'd5, 3'd2);              // east wraps onto itself
    place(9, 7, 3'd6, 3'd4);
    send_item(CMD_STEP, 6'd0, 6'd0, 1'b0, 3'd0, 3'd0);
    peek(0, 3);
    peek(63, 8);
    write_reg(REG_GRID_WIDTH, 32'd64);
    write_reg(REG_GRID_HEIGHT, 32'd0);
    peek(3, 0);
    peek(63, 40);
  endtask

  task automatic test_step_limit();
    write_reg(REG_GRID_WIDTH, 32'd4);
    write_reg(REG_GRID_HEIGHT, 32'd4);
    write_reg(REG_MAX_STEPS, lat_steps);
    send_item(CMD_STEP, 6'd0, 6'd0, 1'b0, 3'd0, 3'd0);
    write_reg(REG_MAX_STEPS, 32'd0);
    send_item(CMD_STEP, 6'd0, 6'd0, 1'b0, 3'd0, 3'd0);
    write_reg(REG_MAX_STEPS, 32'hFFFF_FFFF);
    // results trickle out one at a time: sender waits for each
    place(1, 1, 3'd3, 3'd4);
    wait_drained();
    send_item(CMD_STEP, 6'd0, 6'd0, 1'b0, 3'd0, 3'd0);
    wait_drained();
    peek(1, 2);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input logic [31:0] w,
                                     input logic [31:0] h, input logic [31:0] limit);
    int p;
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_MAX_STEPS, limit);
    idle_mode = $urandom_range(0, 2);
    stall_mode = $urandom_range(0, 2);
    // populate first so steps see a crowded lattice
    for (int k = 0; k < n_items / 4; k++)
      place($urandom_range(0, 63), $urandom_range(0, 63), 3'($urandom), 3'($urandom));
    for (int k = 0; k < n_items; k++) begin
      p = $urandom_range(0, 99);
      if (p < 30)
        send_item(CMD_PLACE, 6'($urandom), 6'($urandom), ($urandom_range(0, 3) != 0),
                  3'($urandom), 3'($urandom));
      else if (p < 50)
        send_item(CMD_DIR, 6'($urandom), 6'($urandom), 1'($urandom), 3'($urandom),
                  3'($urandom));
      else if (p < 65)
        send_item(CMD_STEP, 6'($urandom), 6'($urandom), 1'($urandom), 3'($urandom),
                  3'($urandom));
      else
        send_item(CMD_READ, 6'($urandom), 6'($urandom), 1'($urandom), 3'($urandom),
                  3'($urandom));
    end
  endtask

  initial begin
    lattice_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_full_grid();
    test_size_wrap();
    test_step_limit();
    test_random_traffic(10, $urandom_range(1, 8), $urandom_range(1, 8), 32'hFFFF_FFFF);
    test_random_traffic(10, 32'd1, $urandom_range(2, 6), 32'd1000);
    test_random_traffic(10, $urandom_range(2, 6), 32'd1, 32'd1000);
    test_random_traffic(10, {25'($urandom_range(0, 32'h1FF_FFFF)), 7'd5}, 32'd3,
                        lat_steps + 32'd3);
    test_random_traffic(10, 32'd64, 32'd2, 32'hFFFF_FFFF);
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS lattice_atom_move_step_core");
    end else begin
      $display("FAIL lattice_atom_move_step_core");
    end
    $finish;
  end

endmodule
